// ===== hdl/ascan_pkg.sv =====
// ascan_pkg: shared types and constants for the ADC scan / knob pickup block.
// No dependencies; imported by ascan_cfg and adc_scan_knob_pickup.
package ascan_pkg;

  localparam int NUM_KNOBS_DEF = 4;
  localparam int NUM_CVS_DEF   = 4;

  localparam logic [7:0] THRESH_RESET = 8'd10;
  localparam int         SAMPLE_DROP  = 2;
  localparam int         SAMPLE_W     = 10;
  localparam int         VAL_W        = 8;
  localparam int         CH_W         = 3;

  // register index of unfreeze_threshold
  localparam logic REG_THRESH = 1'b0;

  typedef enum logic [1:0] {
    REQ_SAMPLE    = 2'd0,
    REQ_FREEZE    = 2'd1,
    REQ_READ_KNOB = 2'd2,
    REQ_READ_CV   = 2'd3
  } req_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic [VAL_W-1:0] tracked;
    logic [VAL_W-1:0] value;
  } knob_entry_t;

endpackage

// ===== hdl/ascan_ram.sv =====
// ascan_ram: single-port-write / single-read synchronous RAM with registered read.
// Per-entry valid bits make never-written entries read as zero after reset.
module ascan_ram #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8,
  parameter int AW    = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [WIDTH-1:0] rd_q;
  logic             rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

// ===== hdl/ascan_cfg.sv =====
// ascan_cfg: APB register file holding unfreeze_threshold.
// Depends on ascan_pkg.
module ascan_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  threshold
);
  import ascan_pkg::*;

  logic hit;

  assign pready = 1'b1;
  assign hit    = (paddr[2] == REG_THRESH);

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
    end else if (psel && penable && pwrite && pready && hit) begin
      threshold <= pwdata[VAL_W-1:0];
    end
  end

  assign prdata = hit ? {24'd0, threshold} : 32'd0;

endmodule

// ===== hdl/adc_scan_knob_pickup.sv =====
// adc_scan_knob_pickup: top level, ADC scan sequencer with knob soft takeover.
// Depends on ascan_pkg, ascan_ram (knob and CV stores), ascan_cfg.
//
//   channel | dir | payload
//   --------+-----+------------------------------------------------------
//   s_*     | in  | tuser: req_type; tdata: adc_sample, channel_index, ...
//   m_*     | out | tdata: read_value, next_channel, knob_released
//   apb     | in  | unfreeze_threshold at byte address 0
//
// For each word, the accept edge launches the RAM read; the execute state then
// does the compare and write-back and loads the output register.
// Only one word is in flight, so no forwarding is needed.
// A result waiting in the output register does not block the next accept;
// a second result stalls in the execute cycle until the register frees.
// Reset (rst, synchronous) clears the scan pointer, freeze mask, RAM valid
// bits and sets the threshold to 10; no clearing pass.
module adc_scan_knob_pickup #(
  parameter int NUM_KNOBS = ascan_pkg::NUM_KNOBS_DEF,
  parameter int NUM_CVS   = ascan_pkg::NUM_CVS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // [9:0] adc_sample, [12:10] channel_index,
                                // [20:13] freeze_value, [23:21] zero
  input  logic [1:0]  s_tuser,  // [1:0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // [7:0] read_value, [10:8] next_channel,
                                // [11] knob_released, [15:12] zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ascan_pkg::*;

  localparam int KAW        = (NUM_KNOBS > 1) ? $clog2(NUM_KNOBS) : 1;
  localparam int CV_DEPTH   = (NUM_CVS > 0) ? NUM_CVS : 1;
  localparam int CAW        = (CV_DEPTH > 1) ? $clog2(CV_DEPTH) : 1;
  localparam int SCAN_TOTAL = NUM_KNOBS + NUM_CVS;

  // ---------------- configuration
  logic [7:0] threshold;

  ascan_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .threshold(threshold)
  );

  // ---------------- input decode
  req_e            in_req;
  logic [CH_W-1:0] in_idx;
  logic [7:0]      in_fval;
  logic [7:0]      in_reading;
  logic [CH_W-1:0] sel_ch;
  logic [3:0]      cv_off;
  logic            in_is_knob;
  logic            in_is_cv;
  logic            accept;

  assign in_req     = req_e'(s_tuser);
  assign in_reading = s_tdata[SAMPLE_W-1:SAMPLE_DROP];
  assign in_idx     = s_tdata[12:10];
  assign in_fval    = s_tdata[20:13];

  // scan_channel for samples, channel_index for the rest
  logic [CH_W-1:0] scan_channel;
  assign sel_ch     = (in_req == REQ_SAMPLE) ? scan_channel : in_idx;
  assign in_is_knob = ({1'b0, sel_ch} < 4'(NUM_KNOBS));

  // CV slot: scanned channels sit after the knobs, reads index directly
  always_comb begin
    cv_off   = {1'b0, in_idx};
    in_is_cv = 1'b0;
    case (in_req)
      REQ_SAMPLE: begin
        cv_off   = {1'b0, scan_channel} - 4'(NUM_KNOBS);
        in_is_cv = !in_is_knob && (cv_off < 4'(NUM_CVS));
      end
      REQ_READ_CV: begin
        in_is_cv = (cv_off < 4'(NUM_CVS));
      end
      default: begin
        in_is_cv = 1'b0;
      end
    endcase
  end

  // ---------------- held item
  req_e           req_q;
  logic [7:0]     reading_q;
  logic [7:0]     fval_q;
  logic [KAW-1:0] kaddr_q;
  logic [CAW-1:0] caddr_q;
  logic           is_knob_q;
  logic           is_cv_q;

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q     <= in_req;
      reading_q <= in_reading;
      fval_q    <= in_fval;
      kaddr_q   <= sel_ch[KAW-1:0];
      caddr_q   <= cv_off[CAW-1:0];
      is_knob_q <= in_is_knob;
      is_cv_q   <= in_is_cv;
    end
  end

  // ---------------- stores
  knob_entry_t    krd;
  knob_entry_t    kwr;
  logic [7:0]     crd;
  logic           fire;
  logic           k_wr_en;
  logic           c_wr_en;

  ascan_ram #(
    .DEPTH(NUM_KNOBS),
    .WIDTH($bits(knob_entry_t)),
    .AW   (KAW)
  ) u_knob_ram (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept && in_is_knob),
    .rd_addr(sel_ch[KAW-1:0]),
    .rd_data(krd),
    .wr_en  (k_wr_en),
    .wr_addr(kaddr_q),
    .wr_data(kwr)
  );

  ascan_ram #(
    .DEPTH(CV_DEPTH),
    .WIDTH(VAL_W),
    .AW   (CAW)
  ) u_cv_ram (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept && in_is_cv),
    .rd_addr(cv_off[CAW-1:0]),
    .rd_data(crd),
    .wr_en  (c_wr_en),
    .wr_addr(caddr_q),
    .wr_data(reading_q)
  );

  // ---------------- control FSM
  state_e state;
  state_e state_next;
  logic   slot_free;

  assign slot_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_EXEC;
      ST_EXEC: if (slot_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    fire     = 1'b0;
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_EXEC: fire     = slot_free;
      default: begin
        s_tready = 1'b0;
        fire     = 1'b0;
      end
    endcase
  end

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------- execute: compare, modify, write back
  logic [NUM_KNOBS-1:0] freeze_mask;
  logic [NUM_KNOBS-1:0] freeze_mask_next;
  logic [NUM_KNOBS-1:0] kbit;
  logic [CH_W-1:0]      scan_channel_next;
  logic [3:0]           scan_inc;
  logic                 frozen;
  logic [7:0]           move;
  logic                 release_hit;
  logic [7:0]           rd_val;

  assign kbit   = NUM_KNOBS'(1) << kaddr_q;
  assign frozen = is_knob_q && ((freeze_mask & kbit) != '0);
  assign move   = (reading_q >= krd.tracked) ? (reading_q - krd.tracked)
                                             : (krd.tracked - reading_q);
  assign scan_inc = {1'b0, scan_channel} + 4'd1;

  always_comb begin
    kwr               = krd;
    k_wr_en           = 1'b0;
    c_wr_en           = 1'b0;
    release_hit       = 1'b0;
    rd_val            = '0;
    freeze_mask_next  = freeze_mask;
    scan_channel_next = scan_channel;
    case (req_q)
      REQ_SAMPLE: begin
        if (is_knob_q) begin
          k_wr_en = 1'b1;
          if (frozen) begin
            // soft takeover: jump past threshold, or land on the tracked spot
            release_hit = (move > threshold) || (reading_q == krd.tracked);
            kwr.tracked = reading_q;
            if (release_hit) begin
              kwr.value        = reading_q;
              freeze_mask_next = freeze_mask & ~kbit;
            end
          end else begin
            kwr.value = reading_q;
          end
        end
        c_wr_en = is_cv_q;
        // channel count can reach 16, so compare one bit wider
        if (({1'b0, scan_inc} >= 5'(SCAN_TOTAL)) || (scan_inc > 4'd7)) begin
          scan_channel_next = '0;
        end else begin
          scan_channel_next = scan_inc[CH_W-1:0];
        end
      end
      REQ_FREEZE: begin
        if (is_knob_q) begin
          k_wr_en   = 1'b1;
          kwr.value = fval_q;
          if (!frozen) begin
            kwr.tracked = fval_q;
          end
          freeze_mask_next = freeze_mask | kbit;
        end
      end
      REQ_READ_KNOB: begin
        if (is_knob_q) rd_val = krd.value;
      end
      REQ_READ_CV: begin
        if (is_cv_q) rd_val = crd;
      end
      default: rd_val = '0;
    endcase
    k_wr_en = k_wr_en && fire;
    c_wr_en = c_wr_en && fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_channel <= '0;
      freeze_mask  <= '0;
    end else if (fire) begin
      scan_channel <= scan_channel_next;
      freeze_mask  <= freeze_mask_next;
    end
  end

  // ---------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {4'd0, release_hit, scan_channel_next, rd_val};
    end
  end

endmodule
